### sv/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the process identifier slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int SLOTS_DEF    = 32;
  localparam int ID_BITS_DEF  = 15;

  localparam int KIND_W       = 2;
  localparam int QID_W        = 15;
  localparam int SLOT_FIELD_W = 5;
  localparam int ID_FIELD_W   = 15;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_LOOKUP  = 2'd1,
    KIND_RELEASE = 2'd2
  } psa_kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [QID_W-1:0]        query_id;
    logic [SLOT_FIELD_W-1:0] slot_index;
  } psa_req_t;

  typedef struct packed {
    logic                    ok;
    logic [SLOT_FIELD_W-1:0] slot_out;
    logic [ID_FIELD_W-1:0]   id_out;
  } psa_rsp_t;

endpackage

### sv/process_id_slot_allocator.sv
`timescale 1ns / 1ps
// Allocate tries up to SLOTS+1 identifiers in turn with a table scan for each,
//   and refuses when every identifier tried is taken; lookup scans the table;
//   release reads its one slot.
// Throughput: one request at a time; the single table read port scans one
//   slot per cycle.
// Reset: asynchronous, clears counter and all busy bits; no clearing pass.
// ----------------------------------------------------------------------------
// process_id_slot_allocator
// Process table allocator: allocate, lookup and release of identifier slots.
// ----------------------------------------------------------------------------
module process_id_slot_allocator import psa_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  psa_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output psa_rsp_t out_rsp_o
);

  logic     rsp_valid;
  logic     rsp_ready;
  psa_rsp_t rsp;
  logic     out_valid_q;
  psa_rsp_t out_rsp_q;

  psa_engine #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_req_i),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  // output register frees the engine for the next request
  assign rsp_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && rsp_ready) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### sv/psa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_mem
// Slot identifier table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module psa_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/psa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_engine
// Sequencer: identifier counter, busy bits and table scans through psa_mem.
// ----------------------------------------------------------------------------
module psa_engine import psa_pkg::*; #(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  psa_req_t req_i,
  output logic     rsp_valid_o,
  input  logic     rsp_ready_i,
  output psa_rsp_t rsp_o
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ISS_W  = $clog2(SLOTS + 1);
  localparam int CW     = (ID_BITS > QID_W) ? ID_BITS : QID_W;
  localparam longint unsigned IdSpan = (64'd1 << ID_BITS) - 64'd1;
  localparam int Limit  = (IdSpan < 64'(SLOTS + 1)) ? int'(IdSpan) : SLOTS + 1;
  localparam int TRY_W  = $clog2(Limit + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SCAN,
    ST_REL_READ,
    ST_RESULT
  } state_e;

  state_e              state_q;
  logic [KIND_W-1:0]   kind_q;
  logic [QID_W-1:0]    qid_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [ID_BITS-1:0]  cnt_q;
  logic [TRY_W-1:0]    tries_q;
  logic [SLOTS-1:0]    busy_q;
  logic [ISS_W-1:0]    issue_q;
  logic                cmp_vld_q;
  logic [SLOT_W-1:0]   cmp_idx_q;
  logic                free_found_q;
  logic [SLOT_W-1:0]   free_idx_q;
  psa_rsp_t            rsp_q;

  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic                mem_re;
  logic [SLOT_W-1:0]   mem_raddr;
  logic [ID_BITS-1:0]  mem_rdata;

  logic [ID_BITS-1:0]  cnt_next;
  logic [CW-1:0]       target_cw;
  logic                cmp_busy;
  logic                hit;
  logic                is_last;
  logic                free_now;
  logic                any_free;
  logic [SLOT_W-1:0]   first_free;
  logic                issue_more;
  logic                rel_in_range;

  assign cnt_next     = (cnt_q == '1) ? ID_BITS'(1) : cnt_q + ID_BITS'(1);
  assign target_cw    = (kind_q == KIND_ALLOC) ? CW'(cnt_q) : CW'(qid_q);
  assign cmp_busy     = busy_q[cmp_idx_q];
  assign hit          = cmp_vld_q && cmp_busy && (CW'(mem_rdata) == target_cw);
  assign is_last      = (cmp_idx_q == SLOT_W'(SLOTS - 1));
  assign free_now     = cmp_vld_q && !cmp_busy;
  assign any_free     = free_found_q || free_now;
  assign first_free   = free_found_q ? free_idx_q : cmp_idx_q;
  assign issue_more   = (issue_q < ISS_W'(SLOTS));
  assign rel_in_range = (32'(req_i.slot_index) < 32'(SLOTS));

  // one table read per cycle while scanning; release reads its slot at accept
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = issue_q[SLOT_W-1:0];
    if (state_q == ST_IDLE) begin
      mem_re    = req_valid_i && (req_i.kind == KIND_RELEASE);
      mem_raddr = SLOT_W'(req_i.slot_index);
    end else if (state_q == ST_SCAN) begin
      mem_re    = issue_more;
    end
  end

  // full scan with an unused identifier and a free slot: claim it
  assign mem_we    = (state_q == ST_SCAN) && (kind_q == KIND_ALLOC) && cmp_vld_q &&
                     !hit && is_last && any_free;
  assign mem_waddr = first_free;

  psa_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ID_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cnt_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= '0;
      qid_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      tries_q      <= '0;
      busy_q       <= '0;
      issue_q      <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      rsp_q        <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            kind_q  <= req_i.kind;
            qid_q   <= req_i.query_id;
            idx_q   <= SLOT_W'(req_i.slot_index);
            tries_q <= '0;
            rsp_q   <= '0;
            case (req_i.kind)
              KIND_ALLOC: begin
                state_q <= ST_ADVANCE;
              end
              KIND_LOOKUP: begin
                issue_q      <= '0;
                cmp_vld_q    <= 1'b0;
                free_found_q <= 1'b0;
                state_q      <= ST_SCAN;
              end
              KIND_RELEASE: begin
                state_q <= rel_in_range ? ST_REL_READ : ST_RESULT;
              end
              default: begin
                state_q <= ST_RESULT;
              end
            endcase
          end
        end
        ST_ADVANCE: begin
          if (tries_q == TRY_W'(Limit)) begin
            // every identifier tried is taken
            rsp_q   <= '0;
            state_q <= ST_RESULT;
          end else begin
            cnt_q        <= cnt_next;
            tries_q      <= tries_q + TRY_W'(1);
            issue_q      <= '0;
            cmp_vld_q    <= 1'b0;
            free_found_q <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= issue_more;
          cmp_idx_q <= issue_q[SLOT_W-1:0];
          if (issue_more) begin
            issue_q <= issue_q + ISS_W'(1);
          end
          if (free_now && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= cmp_idx_q;
          end
          if (hit) begin
            if (kind_q == KIND_ALLOC) begin
              state_q <= ST_ADVANCE;
            end else begin
              rsp_q.ok       <= 1'b1;
              rsp_q.slot_out <= SLOT_FIELD_W'(cmp_idx_q);
              rsp_q.id_out   <= qid_q;
              state_q        <= ST_RESULT;
            end
          end else if (cmp_vld_q && is_last) begin
            if (kind_q == KIND_ALLOC && any_free) begin
              busy_q[first_free] <= 1'b1;
              rsp_q.ok           <= 1'b1;
              rsp_q.slot_out     <= SLOT_FIELD_W'(first_free);
              rsp_q.id_out       <= ID_FIELD_W'(cnt_q);
            end else begin
              rsp_q <= '0;
            end
            state_q <= ST_RESULT;
          end
        end
        ST_REL_READ: begin
          busy_q[idx_q]  <= 1'b0;
          rsp_q.ok       <= 1'b1;
          rsp_q.slot_out <= SLOT_FIELD_W'(idx_q);
          rsp_q.id_out   <= busy_q[idx_q] ? ID_FIELD_W'(mem_rdata) : '0;
          state_q        <= ST_RESULT;
        end
        ST_RESULT: begin
          if (rsp_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESULT);
  assign rsp_o       = rsp_q;

  a_alloc_counter_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && kind_q == KIND_ALLOC) |-> (cnt_q != '0))
    else $error("allocation finished with a zero identifier counter");

  a_claim_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> busy_q[$past(mem_waddr)])
    else $error("claimed slot not marked busy");

  a_cmp_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_vld_q) |-> (32'(cmp_idx_q) < 32'(SLOTS)))
    else $error("scan compare index beyond table");

  a_tries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(tries_q) <= 32'(Limit))
    else $error("identifier search exceeded its try bound");

endmodule

### test/tb_process_id_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_process_id_slot_allocator
// Self-checking bench for the process table allocator. Drives allocate,
// lookup, release and unknown-kind requests, keeps a local copy of the table
// and identifier counter to work out each response, and compares every
// response field by field. Runs directed corner cases, a full table, then
// random traffic under mixed gaps and stalls.
// ----------------------------------------------------------------------------
module tb_process_id_slot_allocator;
  import psa_pkg::*;

  localparam int NSLOT     = SLOTS_DEF;
  localparam int PID_MAX   = (1 << ID_BITS_DEF) - 1;
  localparam int RAND_REQS = 280;  // per idle/stall mix
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  psa_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  psa_rsp_t out_rsp_o;

  int gap_pct   = 0;
  int stall_pct = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int n_refused = 0;

  // shadow copy of the process table
  int       pid_ctr = 0;
  logic     slot_taken [NSLOT] = '{default: 1'b0};
  int       slot_pid   [NSLOT] = '{default: 0};
  psa_rsp_t table_rsp_q [$];
  psa_rsp_t rsp_head;

  process_id_slot_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #100_000_000;
    $display("tb_process_id_slot_allocator NOT OK");
    $finish;
  end

  function automatic psa_req_t mk_req(input logic [KIND_W-1:0] kind, input int qid,
                                      input int idx);
    psa_req_t req;
    req.kind       = kind;
    req.query_id   = qid[QID_W-1:0];
    req.slot_index = idx[SLOT_FIELD_W-1:0];
    return req;
  endfunction

  function automatic psa_rsp_t predict_table_op(input psa_req_t req);
    psa_rsp_t rsp;
    int limit;
    int tries;
    int s;
    int idx;
    bit found;
    bit hit;
    rsp   = '0;
    found = 1'b0;
    case (req.kind)
      KIND_ALLOC: begin
        limit = (NSLOT + 1 < PID_MAX) ? NSLOT + 1 : PID_MAX;
        // roll the counter past identifiers still held by busy slots
        for (tries = 0; tries < limit && !found; tries++) begin
          pid_ctr = (pid_ctr >= PID_MAX) ? 1 : pid_ctr + 1;
          hit = 1'b0;
          for (s = 0; s < NSLOT; s++) begin
            if (slot_taken[s] && slot_pid[s] == pid_ctr) hit = 1'b1;
          end
          found = !hit;
        end
        if (found) begin
          for (s = 0; s < NSLOT; s++) begin
            if (!rsp.ok && !slot_taken[s]) begin
              slot_taken[s] = 1'b1;
              slot_pid[s]   = pid_ctr;
              rsp.ok        = 1'b1;
              rsp.slot_out  = s[SLOT_FIELD_W-1:0];
              rsp.id_out    = pid_ctr[ID_FIELD_W-1:0];
            end
          end
        end
        if (!rsp.ok) n_refused++;
      end
      KIND_LOOKUP: begin
        for (s = 0; s < NSLOT; s++) begin
          if (!rsp.ok && slot_taken[s] && slot_pid[s] == int'(req.query_id)) begin
            rsp.ok       = 1'b1;
            rsp.slot_out = s[SLOT_FIELD_W-1:0];
            rsp.id_out   = req.query_id;
          end
        end
      end
      KIND_RELEASE: begin
        idx = int'(req.slot_index);
        if (idx < NSLOT) begin
          rsp.ok       = 1'b1;
          rsp.slot_out = req.slot_index;
          rsp.id_out   = slot_taken[idx] ? slot_pid[idx][ID_FIELD_W-1:0] : '0;
          slot_taken[idx] = 1'b0;
        end
      end
      default: rsp = '0;
    endcase
    return rsp;
  endfunction

  // Present one request, hold it until accepted, then log its expected response.
  task automatic issue_table_req(input psa_req_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    table_rsp_q.push_back(predict_table_op(req));
    n_sent++;
  endtask

  task automatic wait_table_idle();
    in_valid_i <= 1'b0;
    while (table_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_field(input string name, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (table_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, expected none actual %p", $time, out_rsp_o);
        n_errors++;
      end else begin
        rsp_head = table_rsp_q.pop_front();
        if (out_rsp_o.ok !== rsp_head.ok)
          flag_field("ok", 32'(rsp_head.ok), 32'(out_rsp_o.ok));
        if (out_rsp_o.slot_out !== rsp_head.slot_out)
          flag_field("slot_out", 32'(rsp_head.slot_out), 32'(out_rsp_o.slot_out));
        if (out_rsp_o.id_out !== rsp_head.id_out)
          flag_field("id_out", 32'(rsp_head.id_out), 32'(out_rsp_o.id_out));
        n_checked++;
      end
    end
  end

  task automatic test_alloc_first();
    repeat (3) issue_table_req(mk_req(KIND_ALLOC, 0, 0));
  endtask

  task automatic test_lookup_cases();
    issue_table_req(mk_req(KIND_LOOKUP, 2, 0));
    issue_table_req(mk_req(KIND_LOOKUP, 0, 0));         // id 0 is never handed out
    issue_table_req(mk_req(KIND_LOOKUP, PID_MAX, 0));   // not found
    issue_table_req(mk_req(KIND_LOOKUP, 1, NSLOT - 1));
  endtask

  task automatic test_release_cases();
    issue_table_req(mk_req(KIND_RELEASE, 0, 1));        // busy slot
    issue_table_req(mk_req(KIND_RELEASE, 0, 1));        // now free
    issue_table_req(mk_req(KIND_RELEASE, PID_MAX, NSLOT - 1));
    issue_table_req(mk_req(KIND_LOOKUP, 2, 0));         // released id is gone
    issue_table_req(mk_req(KIND_ALLOC, PID_MAX, NSLOT - 1));  // lowest free slot
    issue_table_req(mk_req(KIND_RELEASE, PID_MAX, 0));
  endtask

  task automatic test_unknown_kind();
    issue_table_req(mk_req(KIND_UNUSED, PID_MAX, NSLOT - 1));
    issue_table_req(mk_req(KIND_UNUSED, 0, 0));
  endtask

  task automatic test_table_full();
    int s;
    for (s = 0; s < NSLOT; s++) issue_table_req(mk_req(KIND_RELEASE, 0, s));
    repeat (NSLOT + 2) issue_table_req(mk_req(KIND_ALLOC, 0, 0));
    wait_table_idle();
  endtask

  task automatic test_random_mix(input int gap, input int stall);
    int done;
    int r;
    int qid;
    int idx;
    int probe;
    done      = 0;
    gap_pct   = gap;
    stall_pct = stall;
    while (done < RAND_REQS) begin
      r   = $urandom_range(99);
      qid = $urandom_range(PID_MAX, 0);
      idx = $urandom_range(NSLOT - 1);
      if (r < 5) begin
        issue_table_req(mk_req(KIND_UNUSED, qid, idx));
      end else begin
        if (r < 40) begin
          issue_table_req(mk_req(KIND_ALLOC, qid, idx));
        end else if (r < 70) begin
          // mostly aim at busy slots
          if ($urandom_range(3) != 0)
            for (probe = 0; probe < 8 && !slot_taken[idx]; probe++)
              idx = $urandom_range(NSLOT - 1);
          issue_table_req(mk_req(KIND_RELEASE, qid, idx));
        end else begin
          if ($urandom_range(9) < 7 && slot_taken[idx]) qid = slot_pid[idx];
          issue_table_req(mk_req(KIND_LOOKUP, qid, $urandom_range(NSLOT - 1)));
        end
        done++;
      end
      if ($urandom_range(49) == 0) wait_table_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alloc_first();
    test_lookup_cases();
    test_release_cases();
    test_unknown_kind();
    test_table_full();
    test_random_mix(0, 0);
    test_random_mix(65, 0);
    test_random_mix(0, 65);
    test_random_mix(14, 14);
    wait_table_idle();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (2 * NSLOT + 8) @(posedge clk_i);
    $display("Sent %0d requests (%0d refused allocations), checked %0d responses,",
             n_sent, n_refused, n_checked);
    $display("covering corner cases, a full table and four gap/stall mixes.");
    if (n_errors == 0) begin
      $display("tb_process_id_slot_allocator OK");
    end else begin
      $display("tb_process_id_slot_allocator NOT OK");
    end
    $finish;
  end

endmodule
